>>> hw/rtl/b64se_pkg.sv
// Base64 stream encoder package: job type passed from front to back,
// queue sizing, alphabet constants and the sextet-to-ASCII function.
// No dependencies.
`default_nettype none

package b64se_pkg;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [6:0] PAD_CHAR   = 7'h3D;
	localparam logic [6:0] CHAR_UPPER = 7'h41;
	localparam logic [6:0] CHAR_LOWER = 7'h61;
	localparam logic [6:0] CHAR_DIGIT = 7'h30;
	localparam logic [6:0] CHAR_PLUS  = 7'h2B;
	localparam logic [6:0] CHAR_SLASH = 7'h2F;

	// One accepted byte, expanded into up to four output characters.
	typedef struct packed {
		logic [3:0]      pad;
		logic [3:0][5:0] sx;
		logic [1:0]      last_idx;
		logic            fin;
	} job_t;

	function automatic logic [6:0] sextet_char(input logic [5:0] v);
		logic [6:0] c;
		logic [6:0] w;
		w = {1'b0, v};
		if (v < 6'd26) begin
			c = CHAR_UPPER + w;
		end else if (v < 6'd52) begin
			c = CHAR_LOWER + w - 7'd26;
		end else if (v < 6'd62) begin
			c = CHAR_DIGIT + w - 7'd52;
		end else if (v == 6'd62) begin
			c = CHAR_PLUS;
		end else begin
			c = CHAR_SLASH;
		end
		return c;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/base64_stream_encoder_unit.sv
// Base64 stream encoder top level: front end, job queue, back end.
// Depends on b64se_pkg, b64se_front, b64se_queue, b64se_back.
//
// Encodes a byte stream to standard Base64 ASCII (A-Z a-z 0-9 + /, '='
// padding). Each accepted byte yields one or two characters, or two to
// four on a byte flagged final_byte, which also flushes the partial sextet
// and pads the group. run_end marks the last character of each byte and
// message_end the last character of the message. A byte is accepted
// whenever the two-entry job queue has room; characters leave one per
// cycle from the output register while out_ready is high and a job waits,
// so the output port sets the pace. A byte has 1 to 4 characters (about
// 1.33 on average), and input and output stall independently.
`default_nettype none

module base64_stream_encoder_unit import b64se_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] data_byte,
	input  wire logic       final_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [6:0]      out_char,
	output logic            run_end,
	output logic            message_end
);

	logic push;
	job_t push_job;
	logic q_full;
	logic pop;
	logic head_valid;
	job_t head_job;

	b64se_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.push       (push),
		.push_job   (push_job),
		.q_full     (q_full)
	);

	b64se_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	b64se_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head_job    (head_job),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_char    (out_char),
		.run_end     (run_end),
		.message_end (message_end)
	);

endmodule

`default_nettype wire

>>> hw/rtl/b64se_front.sv
// Front end: accepts bytes, tracks group phase and carry bits, and builds
// one job per byte with its sextets and padding. Depends on b64se_pkg.
`default_nettype none

module b64se_front import b64se_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] data_byte,
	input  wire logic       final_byte,
	output logic            push,
	output job_t            push_job,
	input  wire logic       q_full
);

	logic [1:0] phase_q;
	logic [3:0] carry_q;
	logic [1:0] nphase;
	logic [3:0] ncarry;
	job_t       job;

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;
	assign push_job = job;

	always_comb begin
		job      = '0;
		nphase   = 2'd1;
		ncarry   = {2'b00, data_byte[1:0]};
		case (phase_q)
			2'd1: begin
				job.sx[0] = {carry_q[1:0], data_byte[7:4]};
				nphase    = 2'd2;
				ncarry    = data_byte[3:0];
			end
			2'd2: begin
				job.sx[0]    = {carry_q, data_byte[7:6]};
				job.sx[1]    = data_byte[5:0];
				job.last_idx = 2'd1;
				nphase       = 2'd0;
				ncarry       = 4'd0;
			end
			default: begin
				job.sx[0] = data_byte[7:2];
			end
		endcase
		job.fin = final_byte;
		if (final_byte) begin
			if (nphase == 2'd1) begin
				job.sx[1]    = {ncarry[1:0], 4'd0};
				job.pad[2]   = 1'b1;
				job.pad[3]   = 1'b1;
				job.last_idx = 2'd3;
			end else if (nphase == 2'd2) begin
				job.sx[1]    = {ncarry, 2'd0};
				job.pad[2]   = 1'b1;
				job.last_idx = 2'd2;
			end
			nphase = 2'd0;
			ncarry = 4'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 2'd0;
			carry_q <= 4'd0;
		end else if (push) begin
			phase_q <= nphase;
			carry_q <= ncarry;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/b64se_queue.sv
// Small job FIFO between front and back ends.
// Depends on b64se_pkg for job_t and depth constants.
`default_nettype none

module b64se_queue import b64se_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  job_t      push_job,
	output logic      full,
	input  wire logic pop,
	output logic      head_valid,
	output job_t      head_job
);

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full       = (cnt_q == QCNT_W'(QDEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_job   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/b64se_back.sv
// Back end: walks the head job one character per cycle, while the output is not
// stalled, into the output register, marking the run and message ends. Depends on b64se_pkg.
`default_nettype none

module b64se_back import b64se_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic head_valid,
	input  job_t      head_job,
	output logic      pop,
	output logic       out_valid,
	input  wire logic  out_ready,
	output logic [6:0] out_char,
	output logic       run_end,
	output logic       message_end
);

	logic [1:0] idx_q;
	logic       out_valid_q;
	logic [6:0] char_q;
	logic       run_end_q;
	logic       msg_end_q;
	logic       load;
	logic       at_last;

	assign load    = head_valid && (!out_valid_q || out_ready);
	assign at_last = (idx_q == head_job.last_idx);
	assign pop     = load && at_last;

	assign out_valid   = out_valid_q;
	assign out_char    = char_q;
	assign run_end     = run_end_q;
	assign message_end = msg_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q       <= at_last ? 2'd0 : idx_q + 2'd1;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			char_q    <= head_job.pad[idx_q] ? PAD_CHAR : sextet_char(head_job.sx[idx_q]);
			run_end_q <= at_last;
			msg_end_q <= at_last && head_job.fin;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/b64se_checker.sv
// Port-level checks for the Base64 stream encoder, bound to the top level.
// Depends on b64se_pkg and base64_stream_encoder_unit.
`default_nettype none

module b64se_checker import b64se_pkg::*; (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic [7:0] data_byte,
	input wire logic       final_byte,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [6:0] out_char,
	input wire logic       run_end,
	input wire logic       message_end
);

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(data_byte) && $stable(final_byte))
		else $error("input transaction changed while stalled");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_char)
			&& $stable(run_end) && $stable(message_end))
		else $error("output transaction changed while stalled");

	a_msg_end_is_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && message_end |-> run_end)
		else $error("message_end without run_end");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !run_end |=> out_valid)
		else $error("gap inside the characters of one byte");

	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_char >= CHAR_PLUS && out_char <= 7'h7A)
		else $error("character outside Base64 range");

endmodule

bind base64_stream_encoder_unit b64se_checker u_b64se_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.data_byte   (data_byte),
	.final_byte  (final_byte),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.out_char    (out_char),
	.run_end     (run_end),
	.message_end (message_end)
);

`default_nettype wire

>>> dv/testbench.sv
// Self-checking testbench for base64_stream_encoder_unit: a directed table, then random
// messages under three idle profiles, scored against an in-bench Base64 predictor
// (table rows with literals against those). Depends on b64se_pkg and the encoder RTL.
`default_nettype none

module testbench;
	import b64se_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 20;
	localparam int ITEMS_PER_PHASE = 53;
	localparam int NUM_DIR = 21;

	typedef struct packed {
		logic [6:0] ch;
		logic       run_end;
		logic       msg_end;
	} b64_char_t;

	// lit holds up to four characters, first one in the highest used byte; n == 0 means
	// the row is scored by the predictor only
	typedef struct packed {
		logic [7:0]  b;
		logic        f;
		logic [2:0]  n;
		logic [31:0] lit;
	} dir_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] data_byte = 8'h00;
	logic       final_byte = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [6:0] out_char;
	logic       run_end;
	logic       message_end;

	b64_char_t  pending_chars[$];
	dir_row_t   dir_tab[NUM_DIR];
	logic [1:0] enc_phase = 2'd0;
	logic [3:0] enc_carry = 4'd0;
	int         error_count = 0;
	int         stall_count = 0;
	int         send_idle_pct = 27;
	int         recv_idle_pct = 87;

	base64_stream_encoder_unit u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.data_byte   (data_byte),
		.final_byte  (final_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_char    (out_char),
		.run_end     (run_end),
		.message_end (message_end)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [6:0] b64_symbol(input logic [5:0] v);
		string alphabet;
		byte   c;
		alphabet = {"ABCDEFGHIJKLMNOPQRSTUVWXYZ", "abcdefghijklmnopqrstuvwxyz",
			"0123456789+/"};
		c = alphabet[v];
		return c[6:0];
	endfunction

	// advances the encoder state and returns the characters for one byte
	task automatic encode_byte(input logic [7:0] b, input logic f,
			output logic [6:0] chars[4], output int cnt);
		cnt = 0;
		case (enc_phase)
			2'd1: begin
				chars[cnt++] = b64_symbol({enc_carry[1:0], b[7:4]});
				enc_carry = b[3:0];
				enc_phase = 2'd2;
			end
			2'd2: begin
				chars[cnt++] = b64_symbol({enc_carry, b[7:6]});
				chars[cnt++] = b64_symbol(b[5:0]);
				enc_carry = 4'd0;
				enc_phase = 2'd0;
			end
			default: begin
				chars[cnt++] = b64_symbol(b[7:2]);
				enc_carry = {2'b00, b[1:0]};
				enc_phase = 2'd1;
			end
		endcase
		if (f) begin
			if (enc_phase == 2'd1) begin
				chars[cnt++] = b64_symbol({enc_carry[1:0], 4'b0000});
				chars[cnt++] = PAD_CHAR;
				chars[cnt++] = PAD_CHAR;
			end else if (enc_phase == 2'd2) begin
				chars[cnt++] = b64_symbol({enc_carry, 2'b00});
				chars[cnt++] = PAD_CHAR;
			end
			enc_phase = 2'd0;
			enc_carry = 4'd0;
		end
	endtask

	task automatic send_byte(input logic [7:0] b, input logic f, input logic [2:0] n_lit,
			input logic [31:0] lit);
		logic [6:0] chars[4];
		int         cnt;
		b64_char_t  e;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		final_byte <= f;
		do @(posedge clk); while (!in_ready);
		encode_byte(b, f, chars, cnt);
		if (n_lit != 0) begin
			cnt = n_lit;
			for (int k = 0; k < cnt; k++)
				chars[k] = lit[8 * (cnt - 1 - k) +: 7];
		end
		for (int k = 0; k < cnt; k++) begin
			e.ch = chars[k];
			e.run_end = (k == cnt - 1);
			e.msg_end = (k == cnt - 1) && f;
			pending_chars.push_back(e);
		end
	endtask

	task automatic drain_pending();
		in_valid <= 1'b0;
		while (pending_chars.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_random_messages(input int n_items);
		int         sent;
		int         len;
		logic [7:0] b;
		sent = 0;
		while (sent < n_items) begin
			len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 9);
			for (int k = 0; k < len; k++) begin
				case ($urandom_range(0, 9))
					0: b = 8'h00;
					1: b = 8'hFF;
					default: b = 8'($urandom_range(0, 255));
				endcase
				send_byte(b, k == len - 1, 3'd0, 32'h0);
				sent++;
			end
		end
	endtask

	always @(posedge clk) begin
		b64_char_t e;
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stall_count <= 0;
		else
			stall_count <= stall_count + 1;
		if (stall_count >= STALL_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
			$display("status: fail");
			$finish;
		end
		if (arst_n && out_valid && out_ready) begin
			if (pending_chars.size() == 0) begin
				$display("%0t: unexpected character, expected none, got %h", $time, out_char);
				error_count++;
			end else begin
				e = pending_chars.pop_front();
				if (out_char !== e.ch) begin
					$display("%0t: out_char expected %h got %h", $time, e.ch, out_char);
					error_count++;
				end
				if (run_end !== e.run_end) begin
					$display("%0t: run_end expected %b got %b", $time, e.run_end, run_end);
					error_count++;
				end
				if (message_end !== e.msg_end) begin
					$display("%0t: message_end expected %b got %b", $time, e.msg_end,
						message_end);
					error_count++;
				end
			end
		end
		out_ready <= arst_n && ($urandom_range(0, 99) >= recv_idle_pct);
	end

	initial begin
		dir_tab = '{
			'{8'h00, 1'b1, 3'd4, "AA=="},
			'{8'hFF, 1'b1, 3'd4, "/w=="},
			'{8'h4D, 1'b0, 3'd1, "T"},
			'{8'h61, 1'b1, 3'd3, "WE="},
			'{8'h4D, 1'b0, 3'd1, "T"},
			'{8'h61, 1'b0, 3'd1, "W"},
			'{8'h6E, 1'b1, 3'd2, "Fu"},
			'{8'hFF, 1'b0, 3'd1, "/"},
			'{8'hFF, 1'b0, 3'd1, "/"},
			'{8'hFF, 1'b1, 3'd2, "//"},
			'{8'h00, 1'b0, 3'd1, "A"},
			'{8'h00, 1'b0, 3'd1, "A"},
			'{8'h00, 1'b1, 3'd2, "AA"},
			'{8'hFB, 1'b0, 3'd0, 32'h0},
			'{8'hEF, 1'b0, 3'd0, 32'h0},
			'{8'hBE, 1'b0, 3'd0, 32'h0},
			'{8'h80, 1'b0, 3'd0, 32'h0},
			'{8'h01, 1'b1, 3'd0, 32'h0},
			'{8'h55, 1'b0, 3'd0, 32'h0},
			'{8'hAA, 1'b1, 3'd0, 32'h0},
			'{8'h7F, 1'b1, 3'd0, 32'h0}
		};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < NUM_DIR; i++)
			send_byte(dir_tab[i].b, dir_tab[i].f, dir_tab[i].n, dir_tab[i].lit);
		send_random_messages(ITEMS_PER_PHASE);
		drain_pending();

		send_idle_pct = 87;
		recv_idle_pct = 27;
		send_random_messages(ITEMS_PER_PHASE);
		drain_pending();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_random_messages(ITEMS_PER_PHASE);
		drain_pending();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && pending_chars.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

`default_nettype wire
